// File: rtl/dls_pkg.sv
// Shared types, constants and the sigmoid table builder for the dense layer.
`default_nettype none

package dls_pkg;

  // Default sizes, handed to the top-level parameters.
  localparam int DLS_MAX_FEATURES = 64;
  localparam int DLS_MAX_OUTPUTS  = 2;
  localparam int DLS_SIG_ENTRIES  = 512;

  // Largest table the builder supports.
  localparam int SIG_TAB_MAX = 4096;

  // Fixed field widths.
  localparam int DATA_W     = 16;
  localparam int ACT_W      = 16;
  localparam int OUT_NUM_W  = 1;
  localparam int OC_W       = 2;
  localparam int CMD_W      = 2;
  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // Bias is aligned to the Q8.24 product scale by this shift.
  localparam int BIAS_SHIFT = 12;

  // Half range of the table input in Q8.24 (8.0), and its bit position.
  localparam int SUM_HALF_BIT = 27;

  // Result queue depth in samples.
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = 3;
  localparam int RES_W      = 4;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_FEATURE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WEIGHT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_BIAS    = 2'd2;

  // Register selects (bit 2 of the byte address).
  localparam logic REG_FEATURE_COUNT = 1'b0;
  localparam logic REG_OUTPUT_COUNT  = 1'b1;

  // Control that travels with an accepted beat through the datapath.
  typedef struct packed {
    logic                        valid;
    logic                        feature;
    logic                        ends;
    logic                        bias_we;
    logic [OUT_NUM_W-1:0]        bias_sel;
    logic [OUT_NUM_W-1:0]        last_lane;
    logic signed [DATA_W-1:0]    data;
  } issue_t;

  typedef logic [ACT_W-1:0] sig_tab_t [SIG_TAB_MAX];

  // (a*b) >> 62 for operands below 2^62.
  function automatic logic [63:0] mul_q62(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  // Unsigned long division by shift and subtract, used while building the table.
  function automatic logic [63:0] udiv64(input logic [63:0] dividend,
                                         input logic [63:0] divisor);
    logic [63:0] quo;
    logic [64:0] rem;
    quo = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], dividend[i]};
      if (rem >= {1'b0, divisor}) begin
        rem    = rem - {1'b0, divisor};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sigmoid of each step midpoint over [-8,8), scaled by 65535 and rounded.
  function automatic sig_tab_t build_sig_table(input int unsigned n);
    sig_tab_t    t;
    logic [63:0] term;
    logic [63:0] q;
    logic [63:0] e;
    logic [63:0] e40;
    logic [63:0] den;
    logic [63:0] num;
    logic [63:0] r;
    logic [63:0] step;
    int unsigned half;
    t    = '{default: '0};
    step = 64'(n >> 3);
    term = 64'd1 << 62;
    q    = 64'd1 << 62;
    // exp(-8/n) in Q.62 by its Taylor series.
    for (int k = 1; k < 40; k++) begin
      term = udiv64(term, step * 64'(k));
      if ((k & 1) != 0) q = q - term;
      else q = q + term;
    end
    half = n >> 1;
    e    = q;
    // Fill both halves outward from the centre using symmetry.
    for (int unsigned k = 0; k < half; k++) begin
      e40 = (e + (64'd1 << 21)) >> 22;
      den = (64'd1 << 40) + e40;
      num = 64'd65535 * e40;
      r   = udiv64(64'd2 * num + den, 64'd2 * den);
      t[half - 1 - k] = r[ACT_W-1:0];
      t[half + k]     = ACT_W'(64'd65535 - r);
      e = mul_q62(mul_q62(e, q), q);
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// File: rtl/dls_mac.sv
// Weight memory, multipliers, bias store and per-output accumulators.
`default_nettype none

module dls_mac
  import dls_pkg::*;
#(
  parameter int MAX_FEATURES = DLS_MAX_FEATURES,
  parameter int MAX_OUTPUTS  = DLS_MAX_OUTPUTS,
  parameter int ACC_W        = 40,
  localparam int FA_W        = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  input  issue_t                   issue,
  input  logic [FA_W-1:0]          rd_addr,
  input  logic                     wr_en,
  input  logic [OUT_NUM_W-1:0]     wr_lane,
  input  logic [FA_W-1:0]          wr_addr,
  input  logic signed [DATA_W-1:0] wr_data,
  output logic                     sum_valid,
  output logic [OUT_NUM_W-1:0]     sum_last_lane,
  output logic signed [ACC_W-1:0]  sums [MAX_OUTPUTS]
);

  issue_t                        ctrl1;
  issue_t                        ctrl2;
  logic signed [DATA_W-1:0]      wdata [MAX_OUTPUTS];
  logic signed [2*DATA_W-1:0]    prod  [MAX_OUTPUTS];
  logic signed [ACC_W-1:0]       acc   [MAX_OUTPUTS];
  logic signed [DATA_W-1:0]      bias  [MAX_OUTPUTS];

  // One weight memory per output lane, read by feature position.
  for (genvar j = 0; j < MAX_OUTPUTS; j++) begin : g_wmem
    logic signed [DATA_W-1:0] wmem [MAX_FEATURES];

    always_ff @(posedge clk) begin
      if (wr_en && (wr_lane == OUT_NUM_W'(j))) begin
        wmem[wr_addr] <= wr_data;
      end
      wdata[j] <= wmem[rd_addr];
    end
  end

  // Control pipeline registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl1 <= '0;
      ctrl2 <= '0;
    end else begin
      ctrl1 <= issue;
      ctrl2 <= ctrl1;
    end
  end

  // Product stage: weight times feature, registered before the add.
  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_OUTPUTS; j++) begin
      prod[j] <= wdata[j] * ctrl1.data;
    end
  end

  // Bias writes land in the same stage that reads the bias, keeping order.
  always_ff @(posedge clk) begin
    if (ctrl2.valid && ctrl2.bias_we) begin
      bias[ctrl2.bias_sel] <= ctrl2.data;
    end
  end

  // Accumulate; at the end of a sample form the biased sum and clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < MAX_OUTPUTS; j++) acc[j] <= '0;
      sum_valid <= 1'b0;
    end else begin
      sum_valid <= ctrl2.valid && ctrl2.feature && ctrl2.ends;
      if (ctrl2.valid && ctrl2.feature) begin
        for (int j = 0; j < MAX_OUTPUTS; j++) begin
          if (ctrl2.ends) begin
            acc[j] <= '0;
          end else if (OUT_NUM_W'(j) <= ctrl2.last_lane) begin
            acc[j] <= acc[j] + {{(ACC_W-2*DATA_W){prod[j][2*DATA_W-1]}}, prod[j]};
          end
        end
      end
    end
  end

  // Sum payload, no reset needed.
  always_ff @(posedge clk) begin
    sum_last_lane <= ctrl2.last_lane;
    for (int j = 0; j < MAX_OUTPUTS; j++) begin
      sums[j] <= acc[j]
               + {{(ACC_W-2*DATA_W){prod[j][2*DATA_W-1]}}, prod[j]}
               + {{(ACC_W-DATA_W-BIAS_SHIFT){bias[j][DATA_W-1]}}, bias[j],
                  {BIAS_SHIFT{1'b0}}};
    end
  end

endmodule

`default_nettype wire

// File: rtl/dls_sigmoid.sv
// Sigmoid table ROM with one registered read port per output lane.
`default_nettype none

module dls_sigmoid
  import dls_pkg::*;
#(
  parameter int MAX_OUTPUTS     = DLS_MAX_OUTPUTS,
  parameter int SIGMOID_ENTRIES = DLS_SIG_ENTRIES,
  parameter int ACC_W           = 40,
  localparam int LOG2N          = $clog2(SIGMOID_ENTRIES)
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    sum_valid,
  input  logic [OUT_NUM_W-1:0]    sum_last_lane,
  input  logic signed [ACC_W-1:0] sums [MAX_OUTPUTS],
  output logic                    act_valid,
  output logic [OUT_NUM_W-1:0]    act_last_lane,
  output logic [ACT_W-1:0]        acts [MAX_OUTPUTS]
);

  localparam sig_tab_t SIG_TABLE = build_sig_table(SIGMOID_ENTRIES);
  localparam logic signed [ACC_W-1:0] SUM_HALF = ACC_W'(1) <<< SUM_HALF_BIT;

  logic [LOG2N-1:0] idx [MAX_OUTPUTS];
  logic [ACC_W-1:0] offset [MAX_OUTPUTS];

  // Table index: saturate outside [-8,8), otherwise the top bits of sum+8.
  always_comb begin
    for (int j = 0; j < MAX_OUTPUTS; j++) begin
      offset[j] = sums[j] + SUM_HALF;
      if (sums[j] < -SUM_HALF) begin
        idx[j] = '0;
      end else if (sums[j] >= SUM_HALF) begin
        idx[j] = '1;
      end else begin
        idx[j] = offset[j][SUM_HALF_BIT -: LOG2N];
      end
    end
  end

  // Registered ROM reads.
  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_OUTPUTS; j++) begin
      acts[j] <= SIG_TABLE[idx[j]];
    end
    act_last_lane <= sum_last_lane;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      act_valid <= 1'b0;
    end else begin
      act_valid <= sum_valid;
    end
  end

endmodule

`default_nettype wire

// File: rtl/dls_out_fifo.sv
// Sample result queue that hands out one output lane per beat.
`default_nettype none

module dls_out_fifo
  import dls_pkg::*;
#(
  parameter int MAX_OUTPUTS = DLS_MAX_OUTPUTS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  logic [OUT_NUM_W-1:0] push_last_lane,
  input  logic [ACT_W-1:0]     push_acts [MAX_OUTPUTS],
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [OUT_NUM_W-1:0] output_number,
  output logic [ACT_W-1:0]     activation,
  output logic                 last_of_sample,
  output logic                 sample_pop
);

  logic [ACT_W-1:0]     q_acts [FIFO_DEPTH][MAX_OUTPUTS];
  logic [OUT_NUM_W-1:0] q_last [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr;
  logic [FIFO_PTR_W-1:0] rd_ptr;
  logic [RES_W-1:0]      count;
  logic [OUT_NUM_W-1:0]  lane;
  logic                  out_fire;

  // Head of queue drives the result beat.
  assign out_valid      = (count != '0);
  assign out_fire       = out_valid && out_ready;
  assign output_number  = lane;
  assign activation     = q_acts[rd_ptr][lane];
  assign last_of_sample = (lane == q_last[rd_ptr]);
  assign sample_pop     = out_fire && last_of_sample;

  // Storage, no reset needed.
  always_ff @(posedge clk) begin
    if (push) begin
      q_acts[wr_ptr] <= push_acts;
      q_last[wr_ptr] <= push_last_lane;
    end
  end

  // Pointers, occupancy and lane walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
      lane   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (out_fire) begin
        if (last_of_sample) begin
          rd_ptr <= rd_ptr + 1'b1;
          lane   <= '0;
        end else begin
          lane <= lane + 1'b1;
        end
      end
      count <= count + RES_W'(push) - RES_W'(sample_pop);
    end
  end

  // The upstream credit scheme must never overfill the queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && (count == RES_W'(FIFO_DEPTH)) && !sample_pop))
    else $error("result queue written while full");

  // The lane only advances when a beat is taken.
  a_lane_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(lane))
    else $error("lane moved during a stalled beat");

endmodule

`default_nettype wire

// File: rtl/dense_layer_sigmoid.sv
// Top level of the fully connected layer with table-driven sigmoid outputs.
//
//   Channel   Direction  Handshake          Payload
//   in        sink       in_valid/in_ready  cmd, entry_index, data_value
//   out       source     out_valid/out_ready output_number, activation, last_of_sample
//   apb       slave      psel/penable/pready feature_count @0x0, output_count @0x4
//
// One beat is taken per cycle while in_ready is high; weight/bias beats never stall.
// A sample-ending feature beat moves through the control, sum and table registers into
// the queue; results leave one per cycle while out_ready is high, by the single port.
// in_ready falls only while eight samples are accepted but not yet fully delivered,
// the depth of the result queue.
// Reset clears the counter, accumulators and queue; weight and bias memories hold
// whatever was last written and need no clearing pass.
`default_nettype none

module dense_layer_sigmoid
  import dls_pkg::*;
#(
  parameter int MAX_FEATURES    = DLS_MAX_FEATURES,
  parameter int MAX_OUTPUTS     = DLS_MAX_OUTPUTS,
  parameter int SIGMOID_ENTRIES = DLS_SIG_ENTRIES,
  localparam int IDX_W = (MAX_OUTPUTS * MAX_FEATURES > 1) ?
                         $clog2(MAX_OUTPUTS * MAX_FEATURES) : 1
) (
  input  logic                     clk,
  input  logic                     rst,
  // Input items
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [CMD_W-1:0]         cmd,
  input  logic [IDX_W-1:0]         entry_index,
  input  logic signed [DATA_W-1:0] data_value,
  // Results
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [OUT_NUM_W-1:0]     output_number,
  output logic [ACT_W-1:0]         activation,
  output logic                     last_of_sample,
  // Configuration
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_W-1:0]    paddr,
  input  logic [APB_DATA_W-1:0]    pwdata,
  output logic [APB_DATA_W-1:0]    prdata,
  output logic                     pready
);

  localparam int FA_W  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int FC_W  = ($clog2(MAX_FEATURES + 1) > 7) ? $clog2(MAX_FEATURES + 1) : 7;
  localparam int ACC_W = 2 * DATA_W + FA_W + 2;

  logic [FC_W-1:0]      feature_count;
  logic [OC_W-1:0]      output_count;
  logic [FC_W-1:0]      nf_eff;
  logic [OC_W-1:0]      oc_eff;
  logic [FA_W-1:0]      feature_counter;
  logic [FC_W-1:0]      cnt_plus;
  logic                 accept;
  logic                 is_feature;
  logic                 sample_end;
  logic [RES_W-1:0]     reserved;
  logic [RES_W-1:0]     reserved_next;
  logic                 sample_pop;
  issue_t               issue;
  logic                 wr_en;
  logic                 wr_lane;
  logic [IDX_W:0]       idx_ext;
  logic [IDX_W:0]       wr_off;
  logic                 sum_valid;
  logic [OUT_NUM_W-1:0] sum_last_lane;
  logic signed [ACC_W-1:0] sums [MAX_OUTPUTS];
  logic                 act_valid;
  logic [OUT_NUM_W-1:0] act_last_lane;
  logic [ACT_W-1:0]     acts [MAX_OUTPUTS];

  // Configuration registers, decoded on address bit 2.
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      feature_count <= FC_W'(1);
      output_count  <= OC_W'(2);
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[2])
        REG_FEATURE_COUNT: feature_count <= pwdata[FC_W-1:0];
        REG_OUTPUT_COUNT:  output_count  <= pwdata[OC_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FEATURE_COUNT: prdata = APB_DATA_W'(feature_count);
      REG_OUTPUT_COUNT:  prdata = APB_DATA_W'(output_count);
    endcase
  end

  // Effective counts with out-of-range values clamped.
  always_comb begin
    if (feature_count == '0) nf_eff = FC_W'(1);
    else if (feature_count > FC_W'(MAX_FEATURES)) nf_eff = FC_W'(MAX_FEATURES);
    else nf_eff = feature_count;
    if (output_count == '0) oc_eff = OC_W'(1);
    else if (output_count > OC_W'(MAX_OUTPUTS)) oc_eff = OC_W'(MAX_OUTPUTS);
    else oc_eff = output_count;
  end

  // Accept and classify the incoming beat.
  assign in_ready   = (reserved < RES_W'(FIFO_DEPTH));
  assign accept     = in_valid && in_ready;
  assign is_feature = accept && (cmd == CMD_FEATURE);
  assign cnt_plus   = FC_W'(feature_counter) + FC_W'(1);
  assign sample_end = (cnt_plus >= nf_eff);

  // Weight address split into lane and feature position.
  assign idx_ext = {1'b0, entry_index};
  assign wr_lane = (idx_ext >= (IDX_W+1)'(MAX_FEATURES));
  assign wr_off  = idx_ext - (wr_lane ? (IDX_W+1)'(MAX_FEATURES) : '0);
  assign wr_en   = accept && (cmd == CMD_WEIGHT) &&
                   (idx_ext < (IDX_W+1)'(MAX_OUTPUTS * MAX_FEATURES));

  always_comb begin
    issue.valid     = accept;
    issue.feature   = (cmd == CMD_FEATURE);
    issue.ends      = sample_end;
    issue.bias_we   = (cmd == CMD_BIAS) && (idx_ext < (IDX_W+1)'(MAX_OUTPUTS));
    issue.bias_sel  = entry_index[OUT_NUM_W-1:0];
    issue.last_lane = OUT_NUM_W'(oc_eff - OC_W'(1));
    issue.data      = data_value;
  end

  // Feature position within the sample.
  always_ff @(posedge clk) begin
    if (rst) begin
      feature_counter <= '0;
    end else if (is_feature) begin
      feature_counter <= sample_end ? '0 : cnt_plus[FA_W-1:0];
    end
  end

  // Samples in flight or queued; bounds the result queue occupancy.
  assign reserved_next = reserved + RES_W'(is_feature && sample_end) - RES_W'(sample_pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      reserved <= '0;
    end else begin
      reserved <= reserved_next;
    end
  end

  dls_mac #(
    .MAX_FEATURES (MAX_FEATURES),
    .MAX_OUTPUTS  (MAX_OUTPUTS),
    .ACC_W        (ACC_W)
  ) u_mac (
    .clk           (clk),
    .rst           (rst),
    .issue         (issue),
    .rd_addr       (feature_counter),
    .wr_en         (wr_en),
    .wr_lane       (OUT_NUM_W'(wr_lane)),
    .wr_addr       (wr_off[FA_W-1:0]),
    .wr_data       (data_value),
    .sum_valid     (sum_valid),
    .sum_last_lane (sum_last_lane),
    .sums          (sums)
  );

  dls_sigmoid #(
    .MAX_OUTPUTS     (MAX_OUTPUTS),
    .SIGMOID_ENTRIES (SIGMOID_ENTRIES),
    .ACC_W           (ACC_W)
  ) u_sigmoid (
    .clk           (clk),
    .rst           (rst),
    .sum_valid     (sum_valid),
    .sum_last_lane (sum_last_lane),
    .sums          (sums),
    .act_valid     (act_valid),
    .act_last_lane (act_last_lane),
    .acts          (acts)
  );

  dls_out_fifo #(
    .MAX_OUTPUTS (MAX_OUTPUTS)
  ) u_out_fifo (
    .clk            (clk),
    .rst            (rst),
    .push           (act_valid),
    .push_last_lane (act_last_lane),
    .push_acts      (acts),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .output_number  (output_number),
    .activation     (activation),
    .last_of_sample (last_of_sample),
    .sample_pop     (sample_pop)
  );

  // Credit count never exceeds the queue depth.
  a_reserved_bound: assert property (@(posedge clk) disable iff (rst)
    reserved <= RES_W'(FIFO_DEPTH))
    else $error("sample credit count above queue depth");

  // A finished sum always has a credit held for it.
  a_sum_has_credit: assert property (@(posedge clk) disable iff (rst)
    sum_valid |-> (reserved != '0))
    else $error("sample sum produced without a reserved queue slot");

endmodule

`default_nettype wire
